### rtl/core/pps_pkg.sv
// Shared types for the preemptive priority scheduler.
// Holds the search token carried along the slot cells and the sequencer states.
// No dependencies.
package pps_pkg;

  // Search token passed from cell to cell, one cell per cycle
  typedef struct packed {
    logic        active;     // a tick search is in this stage
    logic        found;      // some ready slot has been taken so far
    logic [7:0]  prio;       // best priority seen so far
    logic [15:0] arrival;    // arrival of the best slot
    logic [15:0] burst;      // burst of the best slot
    logic [15:0] remaining;  // remaining time of the best slot before service
  } tok_t;

  // Tick sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } st_t;

endpackage

### rtl/core/pps_cell.sv
// One task slot of the scheduler: slot state plus one stage of the search chain.
// Depends on pps_pkg for the token type.
module pps_cell import pps_pkg::*; #(
  parameter int IDX_W    = 3,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  // load port
  input  logic             ld_en,
  input  logic [15:0]      ld_arrival,
  input  logic [15:0]      ld_burst,
  input  logic [7:0]       ld_prio,
  // service commit
  input  logic             serve_en,
  input  logic [IDX_W-1:0] serve_idx,
  // time and search chain
  input  logic [31:0]      cur_time,
  input  tok_t             tok_in,
  input  logic [IDX_W-1:0] idx_in,
  output tok_t             tok_out,
  output logic [IDX_W-1:0] idx_out,
  output logic             pending
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid_r, valid_nxt;
  logic        done_r, done_nxt;
  logic [15:0] arrival_r, burst_r, remaining_r, remaining_nxt;
  logic [7:0]  prio_r;
  tok_t        tok_r, tok_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic        ready, take, served;

  // Slot is a candidate when loaded, unfinished and already arrived
  assign ready  = valid_r && !done_r && ({16'b0, arrival_r} <= cur_time);
  assign take   = tok_in.active && ready && (!tok_in.found || (prio_r < tok_in.prio));
  assign served = serve_en && (serve_idx == MY_IDX);

  // Search stage: take over the token if this slot beats the best so far
  always_comb begin
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.prio      = prio_r;
      tok_nxt.arrival   = arrival_r;
      tok_nxt.burst     = burst_r;
      tok_nxt.remaining = remaining_r;
      idx_nxt           = MY_IDX;
    end
  end

  // Slot state update: load restarts, service counts down (saturating)
  always_comb begin
    valid_nxt     = valid_r;
    done_nxt      = done_r;
    remaining_nxt = remaining_r;
    if (ld_en) begin
      valid_nxt     = 1'b1;
      done_nxt      = 1'b0;
      remaining_nxt = ld_burst;
    end else if (served) begin
      if (remaining_r != 16'd0) remaining_nxt = remaining_r - 16'd1;
      if (remaining_r <= 16'd1) done_nxt = 1'b1;
    end
  end

  // Control flops; valid, done and, of the token, only its active bit need a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      done_r       <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      done_r       <= done_nxt;
      tok_r        <= tok_nxt;
    end
  end

  // Payload flops
  always_ff @(posedge clk) begin
    remaining_r     <= remaining_nxt;
    idx_r           <= idx_nxt;
    if (ld_en) begin
      arrival_r <= ld_arrival;
      burst_r   <= ld_burst;
      prio_r    <= ld_prio;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;
  assign pending = valid_r && !done_r;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: top level with the tick sequencer and result register.
// Depends on pps_pkg and pps_cell.
//
// A load item (func 0) writes one task slot; loads to slots at or above NUM_SLOTS are
// dropped. A tick item (func 1) sends a search token down the row of slot cells, one
// cell per cycle; the winner is served as the token leaves the chain, the turnaround
// time is formed in the calc state, and the waiting time is formed as the result enters
// the output register. Inputs are stalled while a tick is in progress; a result waiting
// in the output register does not stall loads, only the delivery of the next tick's
// result.
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [7:0]  in_priority_req,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ran_valid,
  output logic [2:0]  out_ran_slot,
  output logic        out_finished,
  output logic [31:0] out_completion_time,
  output logic [31:0] out_turnaround,
  output logic [31:0] out_waiting,
  output logic        out_all_done
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  st_t         state_r, state_nxt;
  logic [31:0] time_r, time_nxt;
  logic        in_xfer, load_go, start;
  logic        tok_exit, serve_en;
  tok_t        tok [NUM_SLOTS+1];
  logic [IDX_W-1:0] idx_c [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] pend;

  // latched tick result
  logic             hit_r, fin_r, alldone_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      arr_r, burst_r;
  logic [31:0]      tat_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        emit;
  logic        o_ran_r, o_fin_r, o_all_r;
  logic [2:0]  o_slot_r;
  logic [31:0] o_comp_r, o_tat_r, o_wt_r;

  assign in_xfer  = in_valid && !in_stall;
  assign tok_exit = tok[NUM_SLOTS].active;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer && in_func) state_nxt = ST_SCAN;
      ST_SCAN: if (tok_exit) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_EMIT;
      ST_EMIT: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    load_go  = 1'b0;
    start    = 1'b0;
    serve_en = 1'b0;
    emit     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        load_go  = in_xfer && !in_func;
        start    = in_xfer && in_func;
      end
      ST_SCAN: serve_en = tok_exit && tok[NUM_SLOTS].found;
      ST_CALC: ;
      ST_EMIT: emit = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Search token enters the chain at cell 0
  always_comb begin
    tok[0]        = '0;
    tok[0].active = start;
    idx_c[0]      = '0;
  end

  // Row of slot cells
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    logic ld_en;
    assign ld_en = load_go && (32'(in_slot) == g);

    pps_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ld_en      (ld_en),
      .ld_arrival (in_arrival),
      .ld_burst   (in_burst),
      .ld_prio    (in_priority_req),
      .serve_en   (serve_en),
      .serve_idx  (idx_c[NUM_SLOTS]),
      .cur_time   (time_r),
      .tok_in     (tok[g]),
      .idx_in     (idx_c[g]),
      .tok_out    (tok[g+1]),
      .idx_out    (idx_c[g+1]),
      .pending    (pend[g])
    );
  end

  // Time advances once per tick, when the token leaves the chain
  always_comb begin
    time_nxt = time_r;
    if (state_r == ST_SCAN && tok_exit) time_nxt = time_r + 32'd1;
  end

  // Output valid: set on emit, held while stalled
  always_comb begin
    if (emit) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  // Control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Tick result datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && tok_exit) begin
      hit_r   <= tok[NUM_SLOTS].found;
      idx_r   <= idx_c[NUM_SLOTS];
      fin_r   <= tok[NUM_SLOTS].found && (tok[NUM_SLOTS].remaining <= 16'd1);
      arr_r   <= tok[NUM_SLOTS].arrival;
      burst_r <= tok[NUM_SLOTS].burst;
    end
    // cells already reflect the service here
    if (state_r == ST_CALC) begin
      tat_r     <= time_r - {16'b0, arr_r};
      alldone_r <= ~|pend;
    end
    if (emit) begin
      o_ran_r  <= hit_r;
      o_slot_r <= hit_r ? 3'(idx_r) : 3'd0;
      o_fin_r  <= fin_r;
      o_comp_r <= fin_r ? time_r : 32'd0;
      o_tat_r  <= fin_r ? tat_r : 32'd0;
      o_wt_r   <= fin_r ? (tat_r - {16'b0, burst_r}) : 32'd0;
      o_all_r  <= alldone_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ran_valid       = o_ran_r;
  assign out_ran_slot        = o_slot_r;
  assign out_finished        = o_fin_r;
  assign out_completion_time = o_comp_r;
  assign out_turnaround      = o_tat_r;
  assign out_waiting         = o_wt_r;
  assign out_all_done        = o_all_r;

  // Checks
  a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit |-> state_r == ST_SCAN)
    else $error("search token left the chain outside a scan");

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == ST_SCAN && tok[1].active)
    else $error("tick did not launch a search");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result appeared without a tick");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !tok_exit && !serve_en)
    else $error("stray search activity while idle");

endmodule
